// ===== design/prs_pkg.sv =====
// prs_pkg: shared widths, register map, detection codes and payload types
// for the presence reminder sequencer; depends on nothing
`default_nettype none

package prs_pkg;

    // widths
    localparam int TIME_BITS   = 48;
    localparam int MS_BITS     = 27;
    localparam int FAIL_BITS   = 8;
    localparam int STREAK_BITS = 32;
    localparam int ADDR_BITS   = 5;
    localparam int DATA_BITS   = 32;
    localparam int REG_IDX_BITS = 3;

    // register indexes, byte address is 4 * index
    localparam logic [REG_IDX_BITS-1:0] REG_CAPTURE_INTERVAL = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_REMIND_AFTER     = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_ABSENCE_RESET    = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_REPEAT_INTERVAL  = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_SUSPEND_COOLDOWN = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_FAIL_LIMIT       = 3'd5;

    // register reset values
    localparam logic [MS_BITS-1:0]   RST_CAPTURE_INTERVAL = 27'd10000;
    localparam logic [MS_BITS-1:0]   RST_REMIND_AFTER     = 27'd1800000;
    localparam logic [MS_BITS-1:0]   RST_ABSENCE_RESET    = 27'd60000;
    localparam logic [MS_BITS-1:0]   RST_REPEAT_INTERVAL  = 27'd600000;
    localparam logic [MS_BITS-1:0]   RST_SUSPEND_COOLDOWN = 27'd300000;
    localparam logic [FAIL_BITS-1:0] RST_FAIL_LIMIT       = 8'd3;

    // detection outcome and class codes
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_SKIP   = 2'd1;
    localparam logic [1:0] CLASS_PRESENT = 2'd1;
    localparam logic [1:0] CLASS_ABSENT  = 2'd2;

    // one capture tick
    typedef struct packed {
        logic [TIME_BITS-1:0] time_now_ms;
        logic                 user_enabled;
        logic                 output_busy;
        logic [1:0]           detect_status;
        logic                 detect_valid;
        logic [1:0]           detect_class;
    } t_in_item;

    // one result per tick
    typedef struct packed {
        logic [1:0]           alert_count;
        logic [2:0]           mode_now;
        logic                 reminder_deferred;
        logic [FAIL_BITS-1:0] failures_seen;
    } t_out_item;

    // configuration register contents
    typedef struct packed {
        logic [MS_BITS-1:0]   capture_interval_ms;
        logic [MS_BITS-1:0]   remind_after_ms;
        logic [MS_BITS-1:0]   absence_reset_ms;
        logic [MS_BITS-1:0]   repeat_interval_ms;
        logic [MS_BITS-1:0]   suspend_cooldown_ms;
        logic [FAIL_BITS-1:0] fail_limit;
    } t_cfg;

endpackage

`default_nettype wire

// ===== design/prs_regs.sv =====
// prs_regs: configuration register file behind the APB-style port
// depends on prs_pkg for the register map and the t_cfg type
`default_nettype none

module prs_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [prs_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [prs_pkg::DATA_BITS-1:0] pwdata,
    output logic      [prs_pkg::DATA_BITS-1:0] prdata,
    output logic                               pready,
    output prs_pkg::t_cfg                      o_cfg
);

    prs_pkg::t_cfg                         r_cfg;
    logic [prs_pkg::REG_IDX_BITS-1:0]      w_index;
    logic                                  w_write;

    assign pready  = 1'b1;
    assign w_index = paddr[prs_pkg::ADDR_BITS-1:2];
    assign w_write = psel && penable && pwrite && pready;

    // register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.capture_interval_ms <= prs_pkg::RST_CAPTURE_INTERVAL;
            r_cfg.remind_after_ms     <= prs_pkg::RST_REMIND_AFTER;
            r_cfg.absence_reset_ms    <= prs_pkg::RST_ABSENCE_RESET;
            r_cfg.repeat_interval_ms  <= prs_pkg::RST_REPEAT_INTERVAL;
            r_cfg.suspend_cooldown_ms <= prs_pkg::RST_SUSPEND_COOLDOWN;
            r_cfg.fail_limit          <= prs_pkg::RST_FAIL_LIMIT;
        end else if (w_write) begin
            case (w_index)
                prs_pkg::REG_CAPTURE_INTERVAL:
                    r_cfg.capture_interval_ms <= pwdata[prs_pkg::MS_BITS-1:0];
                prs_pkg::REG_REMIND_AFTER:
                    r_cfg.remind_after_ms <= pwdata[prs_pkg::MS_BITS-1:0];
                prs_pkg::REG_ABSENCE_RESET:
                    r_cfg.absence_reset_ms <= pwdata[prs_pkg::MS_BITS-1:0];
                prs_pkg::REG_REPEAT_INTERVAL:
                    r_cfg.repeat_interval_ms <= pwdata[prs_pkg::MS_BITS-1:0];
                prs_pkg::REG_SUSPEND_COOLDOWN:
                    r_cfg.suspend_cooldown_ms <= pwdata[prs_pkg::MS_BITS-1:0];
                prs_pkg::REG_FAIL_LIMIT:
                    r_cfg.fail_limit <= pwdata[prs_pkg::FAIL_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // read mux
    always_comb begin
        case (w_index)
            prs_pkg::REG_CAPTURE_INTERVAL:
                prdata = prs_pkg::DATA_BITS'(r_cfg.capture_interval_ms);
            prs_pkg::REG_REMIND_AFTER:
                prdata = prs_pkg::DATA_BITS'(r_cfg.remind_after_ms);
            prs_pkg::REG_ABSENCE_RESET:
                prdata = prs_pkg::DATA_BITS'(r_cfg.absence_reset_ms);
            prs_pkg::REG_REPEAT_INTERVAL:
                prdata = prs_pkg::DATA_BITS'(r_cfg.repeat_interval_ms);
            prs_pkg::REG_SUSPEND_COOLDOWN:
                prdata = prs_pkg::DATA_BITS'(r_cfg.suspend_cooldown_ms);
            prs_pkg::REG_FAIL_LIMIT:
                prdata = prs_pkg::DATA_BITS'(r_cfg.fail_limit);
            default:
                prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== design/prs_core.sv =====
// prs_core: mode state machine, timestamps and counters, updated once per tick
// depends on prs_pkg for the item, result and configuration types
`default_nettype none

module prs_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire prs_pkg::t_cfg      i_cfg,
    input  wire logic               i_advance,
    input  wire prs_pkg::t_in_item  i_item,
    output prs_pkg::t_out_item      o_result
);

    typedef enum logic [2:0] {
        MODE_IDLE      = 3'd0,
        MODE_ABSENT    = 3'd1,
        MODE_TRACKING  = 3'd2,
        MODE_OVERDUE   = 3'd3,
        MODE_SUSPENDED = 3'd4
    } t_mode;

    t_mode                               r_mode,            n_mode;
    logic [prs_pkg::TIME_BITS-1:0]       r_seat_anchor,     n_seat_anchor;
    logic [prs_pkg::TIME_BITS-1:0]       r_last_reminder,   n_last_reminder;
    logic [prs_pkg::TIME_BITS-1:0]       r_suspend_start,   n_suspend_start;
    logic [prs_pkg::STREAK_BITS-1:0]     r_absence_streak,  n_absence_streak;
    logic [prs_pkg::FAIL_BITS-1:0]       r_failure_count,   n_failure_count;
    logic                                r_pending,         n_pending;
    logic [1:0]                          n_alerts;

    logic [prs_pkg::TIME_BITS-1:0]       w_now;
    logic [prs_pkg::TIME_BITS-1:0]       w_since_suspend;
    logic [prs_pkg::TIME_BITS-1:0]       w_since_seat;
    logic [prs_pkg::TIME_BITS-1:0]       w_since_reminder;
    logic                                w_cooldown_done;
    logic                                w_remind_due;
    logic                                w_repeat_due;
    t_mode                               w_mode_eff;
    logic [prs_pkg::FAIL_BITS-1:0]       w_fail_base;
    logic [prs_pkg::FAIL_BITS-1:0]       w_fail_inc;
    logic [prs_pkg::STREAK_BITS:0]       w_streak_sum;
    logic [prs_pkg::STREAK_BITS-1:0]     w_streak_sat;
    logic                                w_present;
    logic                                w_absent;
    logic                                w_fire;

    // wrapping elapsed times and threshold compares
    assign w_now            = i_item.time_now_ms;
    assign w_since_suspend  = w_now - r_suspend_start;
    assign w_since_seat     = w_now - r_seat_anchor;
    assign w_since_reminder = w_now - r_last_reminder;
    assign w_cooldown_done  =
        w_since_suspend >= prs_pkg::TIME_BITS'(i_cfg.suspend_cooldown_ms);
    assign w_remind_due     =
        w_since_seat >= prs_pkg::TIME_BITS'(i_cfg.remind_after_ms);
    assign w_repeat_due     =
        w_since_reminder >= prs_pkg::TIME_BITS'(i_cfg.repeat_interval_ms);

    // a finished cooldown drops back to absent with the failure count cleared
    assign w_mode_eff  = (r_mode == MODE_SUSPENDED) ? MODE_ABSENT : r_mode;
    assign w_fail_base = (r_mode == MODE_SUSPENDED) ? '0 : r_failure_count;
    assign w_fail_inc  = (w_fail_base == '1) ? w_fail_base
                                             : w_fail_base + prs_pkg::FAIL_BITS'(1);

    // saturating absence streak
    assign w_streak_sum = {1'b0, r_absence_streak}
                        + (prs_pkg::STREAK_BITS + 1)'(i_cfg.capture_interval_ms);
    assign w_streak_sat = w_streak_sum[prs_pkg::STREAK_BITS] ? '1
                        : w_streak_sum[prs_pkg::STREAK_BITS-1:0];

    assign w_present = i_item.detect_valid && (i_item.detect_class == prs_pkg::CLASS_PRESENT);
    assign w_absent  = i_item.detect_valid && (i_item.detect_class == prs_pkg::CLASS_ABSENT);

    // next state for one tick
    always_comb begin
        n_mode           = r_mode;
        n_seat_anchor    = r_seat_anchor;
        n_last_reminder  = r_last_reminder;
        n_suspend_start  = r_suspend_start;
        n_absence_streak = r_absence_streak;
        n_failure_count  = r_failure_count;
        n_pending        = r_pending;
        n_alerts         = 2'd0;
        w_fire           = 1'b0;

        if (!i_item.user_enabled) begin
            n_mode = MODE_IDLE;
        end else if (r_mode == MODE_SUSPENDED && !w_cooldown_done) begin
            // still cooling down, tick has no effect
        end else begin
            n_mode          = w_mode_eff;
            n_failure_count = w_fail_base;

            // deferred reminder plays once the audio path is free
            if (r_pending && !i_item.output_busy) begin
                n_pending = 1'b0;
                n_alerts  = 2'd1;
            end

            case (i_item.detect_status)
                prs_pkg::STATUS_OK: begin
                    n_failure_count = '0;
                    if (w_present) begin
                        n_absence_streak = '0;
                        if (w_mode_eff inside {MODE_IDLE, MODE_ABSENT}) begin
                            n_mode          = MODE_TRACKING;
                            n_seat_anchor   = w_now;
                            n_last_reminder = '0;
                        end else if (w_remind_due) begin
                            if (w_mode_eff == MODE_TRACKING) begin
                                n_mode          = MODE_OVERDUE;
                                n_last_reminder = w_now;
                                w_fire          = 1'b1;
                            end else if (w_repeat_due) begin
                                n_last_reminder = w_now;
                                w_fire          = 1'b1;
                            end
                        end
                    end else if (w_absent) begin
                        n_absence_streak = w_streak_sat;
                        if (w_streak_sat >= prs_pkg::STREAK_BITS'(i_cfg.absence_reset_ms)) begin
                            n_mode           = MODE_ABSENT;
                            n_absence_streak = '0;
                            n_seat_anchor    = '0;
                            n_last_reminder  = '0;
                            n_pending        = 1'b0;
                        end
                    end
                end
                prs_pkg::STATUS_SKIP: begin
                end
                default: begin
                    // failed detection, including the unused status code
                    n_failure_count = w_fail_inc;
                    if (w_fail_inc >= i_cfg.fail_limit) begin
                        n_mode          = MODE_SUSPENDED;
                        n_suspend_start = w_now;
                    end
                end
            endcase

            // a due reminder plays now or waits for the busy flag
            if (w_fire) begin
                if (i_item.output_busy) begin
                    n_pending = 1'b1;
                end else begin
                    n_alerts = n_alerts + 2'd1;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode           <= MODE_ABSENT;
            r_seat_anchor    <= '0;
            r_last_reminder  <= '0;
            r_suspend_start  <= '0;
            r_absence_streak <= '0;
            r_failure_count  <= '0;
            r_pending        <= 1'b0;
        end else if (i_advance) begin
            r_mode           <= n_mode;
            r_seat_anchor    <= n_seat_anchor;
            r_last_reminder  <= n_last_reminder;
            r_suspend_start  <= n_suspend_start;
            r_absence_streak <= n_absence_streak;
            r_failure_count  <= n_failure_count;
            r_pending        <= n_pending;
        end
    end

    // result of the current tick
    assign o_result.alert_count       = n_alerts;
    assign o_result.mode_now          = n_mode;
    assign o_result.reminder_deferred = n_pending;
    assign o_result.failures_seen     = n_failure_count;

    // disabling forces idle on the following cycle
    a_disable_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && !i_item.user_enabled |=> r_mode == MODE_IDLE)
        else $error("mode not idle after a disabled tick");

    // nothing plays while the audio path is busy
    a_busy_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_item.output_busy |-> o_result.alert_count == 2'd0)
        else $error("alert played while busy");

    // an active tick with a free audio path leaves nothing deferred
    a_pending_flushed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_item.user_enabled && !i_item.output_busy
            && r_mode != MODE_SUSPENDED |=> !r_pending)
        else $error("reminder left deferred with audio free");

endmodule

`default_nettype wire

// ===== design/presence_reminder_sequencer.sv =====
// presence_reminder_sequencer: top level with input and result registers
// depends on prs_pkg, prs_regs and prs_core
//
// Usage
//   Input channel: i_in_valid / o_in_stall / i_in_data carries one capture tick
//   per transaction. Output channel: o_out_valid / i_out_stall / o_out_data
//   carries exactly one result per tick, in order.
//   Configuration is written over the APB-style port (psel, penable, pwrite,
//   paddr, pwdata, prdata, pready) at byte address 4 * register index; pready
//   always high; users must write only while no tick is in flight (not enforced).
//   Flow: an accepted tick is registered in the input register, processed by
//   the state update, then registered in the result register and presented
//   on o_out_valid; a stalled receiver can hold it in the input register.
//   Throughput: one tick per cycle while the receiver does not stall; the state
//   update is combinational, three 48-bit elapsed-time compares and the streak
//   adder, so each tick sees the state left by the one before it.
//   Reset (synchronous, active low): mode absent, timestamps and counters
//   cleared, nothing deferred, registers at their default values, both
//   pipeline registers empty.
//   When the receiver stalls, the result register holds its transaction; an
//   empty input register still takes one more tick, then o_in_stall is high
//   until the result is taken.
`default_nettype none

module presence_reminder_sequencer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire prs_pkg::t_in_item             i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output prs_pkg::t_out_item                 o_out_data,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [prs_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [prs_pkg::DATA_BITS-1:0] pwdata,
    output logic      [prs_pkg::DATA_BITS-1:0] prdata,
    output logic                               pready
);

    prs_pkg::t_cfg       w_cfg;
    prs_pkg::t_out_item  w_result;
    prs_pkg::t_in_item   r_in;
    prs_pkg::t_out_item  r_out;
    logic                r_in_valid;
    logic                r_out_valid;
    logic                w_out_free;
    logic                w_advance;
    logic                w_in_accept;

    // configuration registers
    prs_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // per-tick state update
    prs_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_advance (w_advance),
        .i_item    (r_in),
        .o_result  (w_result)
    );

    // pipeline handshake
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_advance   = r_in_valid && w_out_free;
    assign o_in_stall  = r_in_valid && !w_out_free;
    assign w_in_accept = i_in_valid && !o_in_stall;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in <= i_in_data;
        end
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
